FILE: rtl/core/wzs_pkg.sv
// ----------------------------------------------------------------------------
// wzs_pkg
// Shared types, constants and helpers of the weekly zone schedule matcher.
// ----------------------------------------------------------------------------
package wzs_pkg;

  localparam int ZONES          = 4;
  localparam int SLOTS_PER_ZONE = 4;
  localparam int SLOT_NUM       = ZONES * SLOTS_PER_ZONE;

  localparam int ZIDX_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int SIDX_W  = (SLOTS_PER_ZONE > 1) ? $clog2(SLOTS_PER_ZONE) : 1;
  localparam int SADDR_W = (SLOT_NUM > 1) ? $clog2(SLOT_NUM) : 1;

  localparam int MIN_W   = 11;
  localparam int DAYS_W  = 7;
  localparam int WDAY_W  = 3;
  localparam int CNT_W   = 3;
  localparam int FLD_W   = 4;
  localparam int ZN_W    = (ZIDX_W + 1 > CNT_W) ? ZIDX_W + 1 : CNT_W;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_MANUAL  = 2'd2;
  localparam logic [1:0] OP_ALL_OFF = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT  = 1'd1;

  localparam logic [CNT_W-1:0] ZONE_COUNT_RST = CNT_W'(4);

  typedef struct packed {
    logic              active;
    logic [DAYS_W-1:0] days;
    logic [MIN_W-1:0]  stop;
    logic [MIN_W-1:0]  start;
  } slot_t;

  typedef struct packed {
    logic              vld;
    logic [ZIDX_W-1:0] zone;
    logic              want;
    logic              done;
  } eval_upd_t;

  // Sunday-first weekday to Monday-first day mask bit; seven maps to none.
  function automatic logic [DAYS_W-1:0] day_bit(input logic [WDAY_W-1:0] wd);
    logic [DAYS_W-1:0] m;
    begin
      m = '0;
      case (wd)
        3'd0: m[6] = 1'b1;
        3'd1: m[0] = 1'b1;
        3'd2: m[1] = 1'b1;
        3'd3: m[2] = 1'b1;
        3'd4: m[3] = 1'b1;
        3'd5: m[4] = 1'b1;
        3'd6: m[5] = 1'b1;
        default: m = '0;
      endcase
      return m;
    end
  endfunction

endpackage

FILE: rtl/core/weekly_zone_schedule_matcher_core.sv
// ----------------------------------------------------------------------------
// weekly_zone_schedule_matcher_core
// Per-zone watering slot table with tick evaluation and manual overrides.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; in_tuser carries the operation (tick,
//           write slot, set manual flag, all off), in_tdata the rest.
//   out_* : one result per command: valve bits, changed bits, manual flags.
//   cfg_* : register writes (manual mode, zone count), always ready; write
//           only while no command is in flight.
// Timing:
//   A tick or an in-range set-manual with a nonzero zone count walks the
//   slots of the first count zones (count capped at ZONES), one per cycle
//   through a single comparator, before its result is registered. Other
//   commands, and these with a zero count, skip the walk and go straight
//   to the output register. A new command is taken only after that load.
//   in_tready is low from the input transfer until the result is loaded
//   into the output register.
// Reset: valves off, manual flags clear, all slots inactive, auto mode,
//   zone count 4. No clearing pass is needed.
// Stall: a pending result holds the output register; a finished command
//   then waits before loading, and no new command is taken until it does.
// ----------------------------------------------------------------------------
module weekly_zone_schedule_matcher_core import wzs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] zone_index, [3:2] slot_index, [14:4] slot_start, [25:15] slot_end,
  // [32:26] slot_days, [33] slot_active, [34] manual_level, [35] clock_valid,
  // [46:36] minute_of_day, [49:47] weekday_sunday_first, [55:50] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [3:0] valve_outputs, [7:4] changed_mask, [11:8] manual_flags, [15:12] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  mode_r, mode_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ZONES-1:0]      manual_r, manual_nxt;
  logic [ZONES-1:0]      valve_r, valve_nxt;
  logic [ZONES-1:0]      changed_r, changed_nxt;
  logic                  clkv_r, clkv_nxt;
  logic [MIN_W-1:0]      minute_r, minute_nxt;
  logic [DAYS_W-1:0]     day_r, day_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [1:0]            f_op;
  logic [1:0]            f_zone;
  logic [1:0]            f_slot;
  slot_t                 f_entry;
  logic                  f_man_level;
  logic                  f_clkv;
  logic [MIN_W-1:0]      f_minute;
  logic [WDAY_W-1:0]     f_wday;

  logic                  in_xfer;
  logic [CNT_W-1:0]      cnt_sat;
  logic                  zone_ok;
  logic                  slot_ok;
  logic                  wr_en;
  logic [SADDR_W-1:0]    wr_addr;
  logic                  eval_start;
  logic [SADDR_W-1:0]    rd_addr;
  slot_t                 rd_data;
  eval_upd_t             upd;

  assign f_op           = in_tuser[1:0];
  assign f_zone         = in_tdata[1:0];
  assign f_slot         = in_tdata[3:2];
  assign f_entry.start  = in_tdata[14:4];
  assign f_entry.stop   = in_tdata[25:15];
  assign f_entry.days   = in_tdata[32:26];
  assign f_entry.active = in_tdata[33];
  assign f_man_level    = in_tdata[34];
  assign f_clkv         = in_tdata[35];
  assign f_minute       = in_tdata[46:36];
  assign f_wday         = in_tdata[49:47];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign cnt_sat = (int'(count_r) > ZONES) ? CNT_W'(ZONES) : count_r;
  assign zone_ok = (int'(f_zone) < ZONES);
  assign slot_ok = (int'(f_slot) < SLOTS_PER_ZONE);
  assign wr_en   = in_xfer && (f_op == OP_WRITE) && zone_ok && slot_ok;
  assign wr_addr = SADDR_W'(int'(f_zone) * SLOTS_PER_ZONE + int'(f_slot));

  wzs_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (f_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wzs_eval u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (eval_start),
    .zone_cnt    (cnt_sat),
    .manual_mode (mode_r),
    .manual_bits (manual_r),
    .clk_valid   (clkv_r),
    .minute      (minute_r),
    .day_mask    (day_r),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .upd         (upd)
  );

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    manual_nxt   = manual_r;
    valve_nxt    = valve_r;
    changed_nxt  = changed_r;
    clkv_nxt     = clkv_r;
    minute_nxt   = minute_r;
    day_nxt      = day_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    eval_start   = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MANUAL_MODE: mode_nxt  = cfg_data[0];
        REG_ZONE_COUNT:  count_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          clkv_nxt    = f_clkv;
          minute_nxt  = f_minute;
          day_nxt     = day_bit(f_wday);
          changed_nxt = '0;
          state_nxt   = ST_EMIT;
          case (f_op)
            OP_TICK: begin
              if (cnt_sat != '0) begin
                eval_start = 1'b1;
                state_nxt  = ST_WALK;
              end
            end
            OP_MANUAL: begin
              if (zone_ok) begin
                manual_nxt[ZIDX_W'(f_zone)] = f_man_level;
                if (cnt_sat != '0) begin
                  eval_start = 1'b1;
                  state_nxt  = ST_WALK;
                end
              end
            end
            OP_ALL_OFF: begin
              changed_nxt = valve_r;
              manual_nxt  = '0;
              valve_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (upd.vld) begin
          valve_nxt[upd.zone]   = upd.want;
          changed_nxt[upd.zone] = valve_r[upd.zone] ^ upd.want;
        end
        if (upd.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = '0;
          out_data_nxt[FLD_W-1:0]         = FLD_W'(valve_r);
          out_data_nxt[2*FLD_W-1:FLD_W]   = FLD_W'(changed_r);
          out_data_nxt[3*FLD_W-1:2*FLD_W] = FLD_W'(manual_r);
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= 1'b0;
      count_r   <= ZONE_COUNT_RST;
      manual_r  <= '0;
      valve_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      manual_r  <= manual_nxt;
      valve_r   <= valve_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    changed_r  <= changed_nxt;
    clkv_r     <= clkv_nxt;
    minute_r   <= minute_nxt;
    day_r      <= day_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/wzs_slot_store.sv
// ----------------------------------------------------------------------------
// wzs_slot_store
// Slot table: one write port, one read port; active bits cleared by reset.
// ----------------------------------------------------------------------------
module wzs_slot_store import wzs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [SADDR_W-1:0] wr_addr,
  input  slot_t              wr_data,
  input  logic [SADDR_W-1:0] rd_addr,
  output slot_t              rd_data
);

  slot_t               slot_r [SLOT_NUM];
  logic [SLOT_NUM-1:0] active_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr_en) begin
      active_r[wr_addr] <= wr_data.active;
    end
  end

  always_comb begin
    rd_data        = slot_r[rd_addr];
    rd_data.active = active_r[rd_addr];
  end

endmodule

FILE: rtl/core/wzs_eval.sv
// ----------------------------------------------------------------------------
// wzs_eval
// Slot walker: one slot compare per cycle, zone decision after its last slot.
// ----------------------------------------------------------------------------
module wzs_eval import wzs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CNT_W-1:0]   zone_cnt,
  input  logic               manual_mode,
  input  logic [ZONES-1:0]   manual_bits,
  input  logic               clk_valid,
  input  logic [MIN_W-1:0]   minute,
  input  logic [DAYS_W-1:0]  day_mask,
  output logic [SADDR_W-1:0] rd_addr,
  input  slot_t              rd_data,
  output eval_upd_t          upd
);

  logic              busy_r, busy_nxt;
  logic [ZIDX_W-1:0] zone_r, zone_nxt;
  logic [SIDX_W-1:0] slot_r, slot_nxt;
  logic              hit_r, hit_nxt;
  logic              match;
  logic              hit_cur;
  logic              zone_end;
  logic [ZN_W-1:0]   zone_inc;

  assign rd_addr = SADDR_W'(int'(zone_r) * SLOTS_PER_ZONE + int'(slot_r));

  assign match = rd_data.active && (|(rd_data.days & day_mask)) &&
                 (minute >= rd_data.start) && (minute < rd_data.stop);

  assign hit_cur  = hit_r | match;
  assign zone_end = (int'(slot_r) == SLOTS_PER_ZONE - 1);
  assign zone_inc = ZN_W'(zone_r) + ZN_W'(1);

  always_comb begin
    busy_nxt  = busy_r;
    zone_nxt  = zone_r;
    slot_nxt  = slot_r;
    hit_nxt   = hit_r;
    upd.vld   = 1'b0;
    upd.zone  = zone_r;
    upd.want  = manual_mode ? manual_bits[zone_r] : (clk_valid & hit_cur);
    upd.done  = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      zone_nxt = '0;
      slot_nxt = '0;
      hit_nxt  = 1'b0;
    end else if (busy_r) begin
      if (zone_end) begin
        upd.vld  = 1'b1;
        slot_nxt = '0;
        hit_nxt  = 1'b0;
        zone_nxt = ZIDX_W'(zone_inc);
        if (zone_inc == ZN_W'(zone_cnt)) begin
          busy_nxt = 1'b0;
          upd.done = 1'b1;
        end
      end else begin
        slot_nxt = slot_r + SIDX_W'(1);
        hit_nxt  = hit_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      zone_r <= '0;
      slot_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      zone_r <= zone_nxt;
      slot_r <= slot_nxt;
      hit_r  <= hit_nxt;
    end
  end

endmodule

FILE: verif/weekly_zone_schedule_matcher_core_tb.sv
// ----------------------------------------------------------------------------
// weekly_zone_schedule_matcher_core_tb
// Self-checking bench for the zone schedule matcher. A clocked driver sends
// queued commands with random gaps. A clocked monitor stalls at random and
// compares every result with a local model of the slot table, manual flags
// and valves. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module weekly_zone_schedule_matcher_core_tb;
  import wzs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 110;
  localparam int NPHASE      = 12;

  localparam logic [2:0] PH_MODE  [NPHASE] = '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1,
                                               3'd0, 3'd1, 3'd0, 3'd0, 3'd1, 3'd1};
  localparam logic [2:0] PH_COUNT [NPHASE] = '{3'd4, 3'd4, 3'd1, 3'd1, 3'd2, 3'd3,
                                               3'd0, 3'd7, 3'd5, 3'd3, 3'd2, 3'd6};

  typedef struct {
    logic [1:0]        op;
    logic [ZIDX_W-1:0] zone;
    logic [SIDX_W-1:0] slot;
    logic [MIN_W-1:0]  start;
    logic [MIN_W-1:0]  stop;
    logic [DAYS_W-1:0] days;
    logic              active;
    logic              man_on;
    logic              clk_ok;
    logic [MIN_W-1:0]  minute;
    logic [WDAY_W-1:0] wday;
    int                gap;
  } cmd_t;

  typedef struct {
    logic [FLD_W-1:0] valves;
    logic [FLD_W-1:0] changed;
    logic [FLD_W-1:0] manual;
  } valve_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  weekly_zone_schedule_matcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state
  slot_t            sched_q [ZONES][SLOTS_PER_ZONE];
  logic [FLD_W-1:0] man_q   = '0;
  logic [FLD_W-1:0] valve_q = '0;
  logic             mode_q  = 1'b0;
  logic [CNT_W-1:0] count_q = ZONE_COUNT_RST;

  cmd_t       cmd_backlog[$];
  valve_rsp_t expected_valves[$];
  int         hot_min[$];

  cmd_t drv_cmd;
  bit   drv_busy = 1'b0;
  int   drv_wait = 0;
  int   mon_wait = 0;
  int   err_count = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   hold_armed = 1'b0;
  logic rx_hold = 1'b0;
  int   cyc_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [FLD_W-1:0] eval_zones(cmd_t c);
    logic [DAYS_W-1:0] dbit;
    logic [FLD_W-1:0]  prev;
    logic              want;
    int                n;
    slot_t             s;
    if (c.wday == 0) dbit = 7'b1 << 6;
    else if (c.wday <= 6) dbit = 7'b1 << (c.wday - 1);
    else dbit = '0;
    n = (int'(count_q) > ZONES) ? ZONES : int'(count_q);
    prev = valve_q;
    for (int z = 0; z < n; z++) begin
      want = 1'b0;
      if (mode_q) begin
        want = man_q[z];
      end else if (c.clk_ok) begin
        for (int k = 0; k < SLOTS_PER_ZONE; k++) begin
          s = sched_q[z][k];
          if (s.active && (s.days & dbit) != 0 && c.minute >= s.start && c.minute < s.stop)
            want = 1'b1;
        end
      end
      valve_q[z] = want;
    end
    return prev ^ valve_q;
  endfunction

  function automatic void predict_valves(cmd_t c);
    valve_rsp_t r;
    logic [FLD_W-1:0] chg;
    chg = '0;
    case (c.op)
      OP_TICK: chg = eval_zones(c);
      OP_WRITE: begin
        if (int'(c.zone) < ZONES && int'(c.slot) < SLOTS_PER_ZONE)
          sched_q[c.zone][c.slot] = '{active: c.active, days: c.days, stop: c.stop,
                                      start: c.start};
      end
      OP_MANUAL: begin
        if (int'(c.zone) < ZONES) begin
          man_q[c.zone] = c.man_on;
          chg = eval_zones(c);
        end
      end
      default: begin
        chg = valve_q;
        man_q = '0;
        valve_q = '0;
      end
    endcase
    r.valves = valve_q;
    r.changed = chg;
    r.manual = man_q;
    expected_valves.push_back(r);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_cmd(cmd_t c);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[1:0]   = c.zone;
    d[3:2]   = c.slot;
    d[14:4]  = c.start;
    d[25:15] = c.stop;
    d[32:26] = c.days;
    d[33]    = c.active;
    d[34]    = c.man_on;
    d[35]    = c.clk_ok;
    d[46:36] = c.minute;
    d[49:47] = c.wday;
    return d;
  endfunction

  function automatic cmd_t mk_cmd(logic [1:0] op, logic [1:0] zone, logic [1:0] slot,
                                  logic [10:0] start, logic [10:0] stop, logic [6:0] days,
                                  logic active, logic man_on, logic clk_ok,
                                  logic [10:0] minute, logic [2:0] wday);
    cmd_t c;
    c.op = op;
    c.zone = zone;
    c.slot = slot;
    c.start = start;
    c.stop = stop;
    c.days = days;
    c.active = active;
    c.man_on = man_on;
    c.clk_ok = clk_ok;
    c.minute = minute;
    c.wday = wday;
    c.gap = tx_calm ? 0 : $urandom_range(0, 9);
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    return mk_cmd(2'($urandom), 2'($urandom), 2'($urandom), 11'($urandom), 11'($urandom),
                  7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 11'($urandom),
                  3'($urandom));
  endfunction

  // minute of day, mostly on or next to a recently written slot edge
  function automatic logic [10:0] pick_minute();
    int m;
    if (hot_min.size() == 0 || $urandom_range(0, 3) == 0) return 11'($urandom_range(0, 1439));
    m = hot_min[$urandom_range(0, hot_min.size() - 1)] + $urandom_range(0, 2) - 1;
    if (m < 0) m = 0;
    return 11'(m);
  endfunction

  task automatic queue_random(int n);
    cmd_t c;
    int   r;
    int   len;
    for (int i = 0; i < n; i++) begin
      c = rand_cmd();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // raw noise, every field at full width
      end else if (r < 35) begin
        c.op = OP_WRITE;
        c.start = 11'($urandom_range(0, 1430));
        len = ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 20) : $urandom_range(1, 240);
        len = int'(c.start) + len;
        c.stop = 11'((len > 1439) ? 1439 : (len < 0 ? 0 : len));
        c.active = ($urandom_range(0, 5) != 0);
        hot_min.push_back(c.start);
        hot_min.push_back(c.stop);
        while (hot_min.size() > 16) void'(hot_min.pop_front());
      end else if (r < 95) begin
        c.op = (r < 80) ? OP_TICK : OP_MANUAL;
        c.clk_ok = ($urandom_range(0, 9) != 0);
        c.minute = pick_minute();
        c.wday = 3'($urandom_range(0, 6));
      end else begin
        c.op = OP_ALL_OFF;
      end
      cmd_backlog.push_back(c);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (cmd_backlog.size() != 0 || drv_busy || expected_valves.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MANUAL_MODE) mode_q = val[0];
    else count_q = val;
  endtask

  task automatic cmp_field(string name, logic [FLD_W-1:0] exp_v, logic [FLD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      drv_busy = 1'b0;
      drv_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_valves(drv_cmd);
        drv_busy = 1'b0;
      end
      if (!drv_busy && cmd_backlog.size() != 0) begin
        drv_cmd = cmd_backlog.pop_front();
        drv_busy = 1'b1;
        drv_wait = drv_cmd.gap;
      end
      if (drv_busy && drv_wait == 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_cmd(drv_cmd);
        in_tuser <= drv_cmd.op;
      end else begin
        in_tvalid <= 1'b0;
        if (drv_busy) drv_wait--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    valve_rsp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mon_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_valves.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, out_tdata);
          err_count++;
        end else begin
          e = expected_valves.pop_front();
          cmp_field("valve_outputs", e.valves, out_tdata[3:0]);
          cmp_field("changed_mask", e.changed, out_tdata[7:4]);
          cmp_field("manual_flags", e.manual, out_tdata[11:8]);
        end
        mon_wait = rx_calm ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (mon_wait > 0) begin
        mon_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cyc_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [2:0] md;
    for (int z = 0; z < ZONES; z++)
      for (int k = 0; k < SLOTS_PER_ZONE; k++) sched_q[z][k] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // auto mode at reset settings
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 0, 0, 0, 1439, 7'h7f, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 1, 3, 2040, 2047, 7'h40, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 2, 1, 600, 600, 7'h7f, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 3, 2, 100, 200, 7'h7f, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_WRITE, 3, 0, 1439, 2047, 7'h01, 1, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 1439, 1));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 2046, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 2047, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 500, 7));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 600, 2));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 600, 2));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 150, 3));
    cmd_backlog.push_back(mk_cmd(OP_MANUAL, 2, 0, 0, 0, 0, 0, 1, 1, 10, 3));
    cmd_backlog.push_back(mk_cmd(OP_MANUAL, 0, 3, 2047, 2047, 7'h7f, 1, 0, 1, 10, 3));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 3, 3, 2047, 2047, 7'h7f, 1, 1, 1, 2047, 6));
    cmd_backlog.push_back(mk_cmd(OP_ALL_OFF, 3, 3, 2047, 2047, 7'h7f, 1, 1, 1, 2047, 7));
    wait_drained();

    // manual mode
    write_reg(REG_MANUAL_MODE, 3'b111);
    cmd_backlog.push_back(mk_cmd(OP_MANUAL, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_MANUAL, 3, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_ALL_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    wait_drained();

    for (int p = 0; p < NPHASE; p++) begin
      tx_calm = (p % 4 == 3) || (p == 1);
      rx_calm = (p % 4 == 3);
      md = 3'($urandom_range(0, 7));
      md[0] = PH_MODE[p][0];
      write_reg(REG_MANUAL_MODE, md);
      write_reg(REG_ZONE_COUNT, PH_COUNT[p]);
      if (p == 1) hold_armed = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (24) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
